### rtl/gpbq_pkg.sv
package gpbq_pkg;

    localparam int unsigned MAP_CELLS = 65536;
    localparam int unsigned MAX_DIM   = 4096;

    localparam int ADDR_W = $clog2(MAP_CELLS);
    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int OFF_W  = IDX_W + DIM_W;

    localparam int DIFF_W = 33;
    localparam int PROD_W = 65;
    localparam int SUM_W  = 66;
    localparam int POS_W  = 34;

    localparam logic signed [7:0] UNKNOWN_CELL = -8'sd1;

    typedef enum logic [2:0] {
        CFG_ORIGIN_X         = 3'd0,
        CFG_ORIGIN_Y         = 3'd1,
        CFG_SCALED_COS       = 3'd2,
        CFG_SCALED_SIN       = 3'd3,
        CFG_MAP_ROWS         = 3'd4,
        CFG_MAP_COLS         = 3'd5,
        CFG_BLOCK_LEVEL      = 3'd6,
        CFG_UNKNOWN_OBSTACLE = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] scaled_cos;
        logic signed [31:0] scaled_sin;
        logic [12:0]        map_rows;
        logic [12:0]        map_cols;
        logic [6:0]         block_level;
        logic               unknown_blocked;
    } cfg_t;

    typedef struct packed {
        logic               opcode;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic [15:0]        cell_address;
        logic signed [7:0]  cell_value;
    } in_item_t;

    typedef struct packed {
        logic               opcode;
        logic [15:0]        cell_address;
        logic signed [7:0]  cell_value;
    } wr_t;

    typedef struct packed {
        wr_t                     wr;
        logic signed [POS_W-1:0] row;
        logic signed [POS_W-1:0] col;
    } grid_item_t;

    typedef struct packed {
        logic               opcode;
        logic               hit;
        logic [ADDR_W-1:0]  mem_addr;
        logic signed [7:0]  cell_value;
        logic               in_grid;
        logic signed [15:0] row;
        logic signed [15:0] col;
    } cell_item_t;

endpackage

### rtl/grid_point_blocked_query.sv
// Occupancy grid point lookup.
// Input channel (s_valid/s_ready) takes one item per cycle while s_ready is high: opcode 1 writes
// s_cell_value to the cell store at s_cell_address, opcode 0 queries the
// Q16.16 world point (s_point_x, s_point_y). Each query gives one result on
// the m_ channel (row, column, inside flag, occupancy, blocked); writes give
// none. Items leave in the order they arrive, so a write affects every later
// query and no earlier one.
// Configuration port (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
// ready; write it only while no item is in flight.
// Throughput: one item per cycle while s_ready is high, set by the single-ported cell store read
// in one pipeline stage and by the four 32x33 multipliers in another.
// Reset clears all valid bits and restores the configuration defaults; the
// cell store is not cleared and must be written before it is queried.
// When m_ready is low the result holds and the pipeline fills its empty
// stages; s_ready falls only once every stage holds an item.
module grid_point_blocked_query (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_opcode,
    input  logic signed [31:0] s_point_x,
    input  logic signed [31:0] s_point_y,
    input  logic [15:0]        s_cell_address,
    input  logic signed [7:0]  s_cell_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_inside_res,
    output logic signed [15:0] m_cell_row,
    output logic signed [15:0] m_cell_col,
    output logic signed [7:0]  m_occupancy_value,
    output logic               m_blocked
);

    gpbq_pkg::cfg_t       cfg_reg;
    gpbq_pkg::in_item_t   in_item;
    gpbq_pkg::grid_item_t grid_item;
    gpbq_pkg::cell_item_t cell_item;
    logic grid_valid, grid_ready, cell_valid, cell_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.origin_x        <= 32'sd0;
            cfg_reg.origin_y        <= 32'sd0;
            cfg_reg.scaled_cos      <= 32'sd65536;
            cfg_reg.scaled_sin      <= 32'sd0;
            cfg_reg.map_rows        <= 13'd256;
            cfg_reg.map_cols        <= 13'd256;
            cfg_reg.block_level     <= 7'd65;
            cfg_reg.unknown_blocked <= 1'b1;
        end else if (cfg_valid) begin
            unique case (gpbq_pkg::cfg_reg_t'(cfg_index))
                gpbq_pkg::CFG_ORIGIN_X:         cfg_reg.origin_x <= cfg_data;
                gpbq_pkg::CFG_ORIGIN_Y:         cfg_reg.origin_y <= cfg_data;
                gpbq_pkg::CFG_SCALED_COS:       cfg_reg.scaled_cos <= cfg_data;
                gpbq_pkg::CFG_SCALED_SIN:       cfg_reg.scaled_sin <= cfg_data;
                gpbq_pkg::CFG_MAP_ROWS:         cfg_reg.map_rows <= cfg_data[12:0];
                gpbq_pkg::CFG_MAP_COLS:         cfg_reg.map_cols <= cfg_data[12:0];
                gpbq_pkg::CFG_BLOCK_LEVEL:      cfg_reg.block_level <= cfg_data[6:0];
                gpbq_pkg::CFG_UNKNOWN_OBSTACLE: cfg_reg.unknown_blocked <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign in_item.opcode       = s_opcode;
    assign in_item.point_x      = s_point_x;
    assign in_item.point_y      = s_point_y;
    assign in_item.cell_address = s_cell_address;
    assign in_item.cell_value   = s_cell_value;

    gpbq_arith u_arith (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (in_item),
        .out_valid (grid_valid),
        .out_ready (grid_ready),
        .out_item  (grid_item)
    );

    gpbq_index u_index (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (grid_valid),
        .in_ready  (grid_ready),
        .in_item   (grid_item),
        .out_valid (cell_valid),
        .out_ready (cell_ready),
        .out_item  (cell_item)
    );

    gpbq_cells u_cells (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .in_valid        (cell_valid),
        .in_ready        (cell_ready),
        .in_item         (cell_item),
        .out_valid       (m_valid),
        .out_ready       (m_ready),
        .inside_res      (m_inside_res),
        .cell_row        (m_cell_row),
        .cell_col        (m_cell_col),
        .occupancy_value (m_occupancy_value),
        .blocked         (m_blocked)
    );

endmodule

### rtl/gpbq_arith.sv
module gpbq_arith (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  gpbq_pkg::cfg_t        cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  gpbq_pkg::in_item_t    in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output gpbq_pkg::grid_item_t  out_item
);

    logic v1_reg, v2_reg, v3_reg;
    logic adv1, adv2, adv3;

    gpbq_pkg::wr_t wr1_reg, wr2_reg, wr3_reg;
    logic signed [gpbq_pkg::DIFF_W-1:0] dx_reg, dy_reg;
    logic signed [gpbq_pkg::PROD_W-1:0] p_cx_reg, p_sy_reg, p_cy_reg, p_sx_reg;
    logic signed [gpbq_pkg::SUM_W-1:0]  col_sum, row_sum;
    logic signed [gpbq_pkg::POS_W-1:0]  row_reg, col_reg;

    assign adv3     = !v3_reg || out_ready;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
        end
    end

    assign col_sum = gpbq_pkg::SUM_W'(p_cx_reg) + gpbq_pkg::SUM_W'(p_sy_reg);
    assign row_sum = gpbq_pkg::SUM_W'(p_cy_reg) - gpbq_pkg::SUM_W'(p_sx_reg);

    always_ff @(posedge aclk) begin
        if (adv1) begin
            wr1_reg.opcode       <= in_item.opcode;
            wr1_reg.cell_address <= in_item.cell_address;
            wr1_reg.cell_value   <= in_item.cell_value;
            dx_reg <= gpbq_pkg::DIFF_W'(in_item.point_x) - gpbq_pkg::DIFF_W'(cfg.origin_x);
            dy_reg <= gpbq_pkg::DIFF_W'(in_item.point_y) - gpbq_pkg::DIFF_W'(cfg.origin_y);
        end
        if (adv2) begin
            wr2_reg  <= wr1_reg;
            p_cx_reg <= gpbq_pkg::PROD_W'(cfg.scaled_cos) * gpbq_pkg::PROD_W'(dx_reg);
            p_sy_reg <= gpbq_pkg::PROD_W'(cfg.scaled_sin) * gpbq_pkg::PROD_W'(dy_reg);
            p_cy_reg <= gpbq_pkg::PROD_W'(cfg.scaled_cos) * gpbq_pkg::PROD_W'(dy_reg);
            p_sx_reg <= gpbq_pkg::PROD_W'(cfg.scaled_sin) * gpbq_pkg::PROD_W'(dx_reg);
        end
        if (adv3) begin
            wr3_reg <= wr2_reg;
            col_reg <= col_sum[gpbq_pkg::SUM_W-1:32];
            row_reg <= row_sum[gpbq_pkg::SUM_W-1:32];
        end
    end

    assign out_valid    = v3_reg;
    assign out_item.wr  = wr3_reg;
    assign out_item.row = row_reg;
    assign out_item.col = col_reg;

endmodule

### rtl/gpbq_index.sv
module gpbq_index (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  gpbq_pkg::cfg_t        cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  gpbq_pkg::grid_item_t  in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output gpbq_pkg::cell_item_t  out_item
);

    function automatic logic signed [15:0] sat16(input logic signed [gpbq_pkg::POS_W-1:0] v);
        logic signed [15:0] r;
        if (v > 34'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -34'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    logic v4_reg, v5_reg;
    logic adv4, adv5;

    logic [gpbq_pkg::DIM_W-1:0] rows_eff, cols_eff;
    logic in_grid;

    gpbq_pkg::wr_t              wr4_reg;
    logic                       inside4_reg;
    logic [gpbq_pkg::IDX_W-1:0] row_idx4_reg, col_idx4_reg;
    logic signed [15:0]         row4_reg, col4_reg;

    logic [gpbq_pkg::OFF_W-1:0] offset;
    logic                       hit;
    logic [gpbq_pkg::ADDR_W-1:0] mem_addr;

    gpbq_pkg::cell_item_t item5_reg;

    assign adv5     = !v5_reg || out_ready;
    assign adv4     = !v4_reg || adv5;
    assign in_ready = adv4;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (adv4) v4_reg <= in_valid;
            if (adv5) v5_reg <= v4_reg;
        end
    end

    assign rows_eff = (32'(cfg.map_rows) > gpbq_pkg::MAX_DIM) ?
                      gpbq_pkg::DIM_W'(gpbq_pkg::MAX_DIM) : gpbq_pkg::DIM_W'(cfg.map_rows);
    assign cols_eff = (32'(cfg.map_cols) > gpbq_pkg::MAX_DIM) ?
                      gpbq_pkg::DIM_W'(gpbq_pkg::MAX_DIM) : gpbq_pkg::DIM_W'(cfg.map_cols);

    assign in_grid = !in_item.row[gpbq_pkg::POS_W-1] && !in_item.col[gpbq_pkg::POS_W-1]
                  && ($unsigned(in_item.row) < gpbq_pkg::POS_W'(rows_eff))
                  && ($unsigned(in_item.col) < gpbq_pkg::POS_W'(cols_eff));

    always_ff @(posedge aclk) begin
        if (adv4) begin
            wr4_reg      <= in_item.wr;
            inside4_reg  <= in_grid;
            row_idx4_reg <= in_item.row[gpbq_pkg::IDX_W-1:0];
            col_idx4_reg <= in_item.col[gpbq_pkg::IDX_W-1:0];
            row4_reg     <= sat16(in_item.row);
            col4_reg     <= sat16(in_item.col);
        end
    end

    assign offset = gpbq_pkg::OFF_W'(row_idx4_reg) * gpbq_pkg::OFF_W'(cols_eff)
                  + gpbq_pkg::OFF_W'(col_idx4_reg);

    always_comb begin
        if (wr4_reg.opcode) begin
            hit      = 32'(wr4_reg.cell_address) < gpbq_pkg::MAP_CELLS;
            mem_addr = gpbq_pkg::ADDR_W'(wr4_reg.cell_address);
        end else begin
            hit      = inside4_reg && (32'(offset) < gpbq_pkg::MAP_CELLS);
            mem_addr = gpbq_pkg::ADDR_W'(offset);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv5) begin
            item5_reg.opcode     <= wr4_reg.opcode;
            item5_reg.hit        <= hit;
            item5_reg.mem_addr   <= mem_addr;
            item5_reg.cell_value <= wr4_reg.cell_value;
            item5_reg.in_grid    <= inside4_reg;
            item5_reg.row        <= row4_reg;
            item5_reg.col        <= col4_reg;
        end
    end

    assign out_valid = v5_reg;
    assign out_item  = item5_reg;

endmodule

### rtl/gpbq_cells.sv
module gpbq_cells (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  gpbq_pkg::cfg_t        cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  gpbq_pkg::cell_item_t  in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  inside_res,
    output logic signed [15:0]    cell_row,
    output logic signed [15:0]    cell_col,
    output logic signed [7:0]     occupancy_value,
    output logic                  blocked
);

    logic signed [7:0] cell_mem [gpbq_pkg::MAP_CELLS];

    logic v6_reg, v7_reg;
    logic adv6, adv7;

    gpbq_pkg::cell_item_t item6_reg;
    logic signed [7:0]    rd_data_reg;

    logic signed [7:0] value;
    logic              blk;

    logic               inside_reg;
    logic signed [15:0] row_reg, col_reg;
    logic signed [7:0]  value_reg;
    logic               blocked_reg;

    assign adv7     = !v7_reg || out_ready;
    assign adv6     = !v6_reg || adv7;
    assign in_ready = adv6;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else begin
            if (adv6) v6_reg <= in_valid;
            if (adv7) v7_reg <= v6_reg && !item6_reg.opcode;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv6) begin
            if (in_valid && in_item.opcode && in_item.hit) begin
                cell_mem[in_item.mem_addr] <= in_item.cell_value;
            end
            rd_data_reg <= cell_mem[in_item.mem_addr];
            item6_reg   <= in_item;
        end
    end

    assign value = item6_reg.hit ? rd_data_reg : gpbq_pkg::UNKNOWN_CELL;
    assign blk   = value[7] ? cfg.unknown_blocked
                            : ($unsigned(value) >= {1'b0, cfg.block_level});

    always_ff @(posedge aclk) begin
        if (adv7) begin
            inside_reg  <= item6_reg.in_grid;
            row_reg     <= item6_reg.row;
            col_reg     <= item6_reg.col;
            value_reg   <= value;
            blocked_reg <= blk;
        end
    end

    assign out_valid       = v7_reg;
    assign inside_res      = inside_reg;
    assign cell_row        = row_reg;
    assign cell_col        = col_reg;
    assign occupancy_value = value_reg;
    assign blocked         = blocked_reg;

endmodule

### rtl/gpbq_checker.sv
module gpbq_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               cfg_valid,
    input logic               cfg_ready,
    input logic [2:0]         cfg_index,
    input logic [31:0]        cfg_data,
    input logic               s_valid,
    input logic               s_ready,
    input logic               s_opcode,
    input logic signed [31:0] s_point_x,
    input logic signed [31:0] s_point_y,
    input logic [15:0]        s_cell_address,
    input logic signed [7:0]  s_cell_value,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_inside_res,
    input logic signed [15:0] m_cell_row,
    input logic signed [15:0] m_cell_col,
    input logic signed [7:0]  m_occupancy_value,
    input logic               m_blocked
);

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_outside_unknown: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_inside_res |-> m_occupancy_value == -8'sd1)
        else $error("outside point with known occupancy");

    a_inside_nonneg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_inside_res |-> !m_cell_row[15] && !m_cell_col[15])
        else $error("inside point with negative index");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cell_row) && $stable(m_cell_col)
            && $stable(m_occupancy_value) && $stable(m_blocked))
        else $error("stalled result changed");

endmodule

bind grid_point_blocked_query gpbq_checker u_gpbq_checker (.*);
